// ----- design/tli_pkg.sv -----
// Shared types and constants for the text line index lookup block.
// No dependencies; imported by text_line_index_lookup and its testbench.
package tli_pkg;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 16;
  localparam int LINENO_W = 16;
  localparam int STATUS_W = 2;
  localparam int LINE_W   = 11;
  localparam int POS_W    = 13;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POS    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LINE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOLINE = 2'd2;

  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

endpackage

// ----- design/tli_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on tli_pkg only by project convention; no types used from it.
module tli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/text_line_index_lookup.sv -----
// Top level of the text line index lookup block: command decode, search FSM,
// output register. Depends on tli_pkg and tli_ram (text store, line-start table).
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid/in_ready, in_cmd, in_text_byte,           | to block
//          | in_query_offset, in_line_query                     |
//  out     | out_valid/out_ready, out_status, out_line_found,   | from block
//          | out_column_found, out_line_begin, out_line_length  |
//
// Steps: append and clear go straight to FIN; a position query makes k <=
// ceil(log2(line_count)) table reads (one compare per read of the line-start
// RAM); a line query reads its line-start entries, then trims trailing CR/LF
// bytes (one text RAM read each); a line that does not exist goes straight to
// FIN. One transaction is worked at a time.
// Reset: synchronous active-low rst_n; text length 0, one line, no pending
// result. Entry zero of the line-start table is never stored: it reads as 0.
// Stalls: a finished result waits in the FIN state until the output register
// frees; the output register holds while out_ready is low.
module text_line_index_lookup #(
  parameter int TEXT_DEPTH = 4096,
  parameter int LINE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tli_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tli_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic [tli_pkg::OFFSET_W-1:0]  in_query_offset,
  input  logic [tli_pkg::LINENO_W-1:0]  in_line_query,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tli_pkg::STATUS_W-1:0]  out_status,
  output logic [tli_pkg::LINE_W-1:0]    out_line_found,
  output logic [tli_pkg::POS_W-1:0]     out_column_found,
  output logic [tli_pkg::POS_W-1:0]     out_line_begin,
  output logic [tli_pkg::POS_W-1:0]     out_line_length
);

  import tli_pkg::*;

  // Counter widths hold the depth itself; address widths index the RAMs.
  localparam int TW  = $clog2(TEXT_DEPTH + 1);
  localparam int LW  = $clog2(LINE_DEPTH + 1);
  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int LAW = $clog2(LINE_DEPTH);
  localparam int OW  = (TW > OFFSET_W) ? TW : OFFSET_W;
  localparam int QW  = (LW > LINENO_W) ? LW : LINENO_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PSRCH = 8'b0000_0010,
    S_PCMP  = 8'b0000_0100,
    S_LRD0  = 8'b0000_1000,
    S_LRD1  = 8'b0001_0000,
    S_TRD   = 8'b0010_0000,
    S_TCMP  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [TW-1:0] text_len_r, text_len_nxt;
  logic [LW-1:0] line_cnt_r, line_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers of the current transaction
  logic [TW-1:0] off_r, off_nxt;
  logic [LW-1:0] lo_r, lo_nxt;
  logic [LW-1:0] hi_r, hi_nxt;
  logic [LW-1:0] mid_r, mid_nxt;
  logic [TW-1:0] lo_val_r, lo_val_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          zero_r, zero_nxt;
  logic [TW-1:0] start_r, start_nxt;
  logic [TW-1:0] end_r, end_nxt;

  // Staged result and output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [LINE_W-1:0]   res_line_r, res_line_nxt;
  logic [POS_W-1:0]    res_col_r, res_col_nxt;
  logic [POS_W-1:0]    res_begin_r, res_begin_nxt;
  logic [POS_W-1:0]    res_len_r, res_len_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [LINE_W-1:0]   out_line_r, out_line_nxt;
  logic [POS_W-1:0]    out_col_r, out_col_nxt;
  logic [POS_W-1:0]    out_begin_r, out_begin_nxt;
  logic [POS_W-1:0]    out_len_r, out_len_nxt;

  // RAM ports
  logic              txt_we, txt_re;
  logic [TAW-1:0]    txt_waddr, txt_raddr;
  logic [BYTE_W-1:0] txt_wdata, txt_q;
  logic              tab_we, tab_re;
  logic [LAW-1:0]    tab_waddr, tab_raddr;
  logic [TW-1:0]     tab_wdata, tab_q;

  // Helpers
  logic          in_fire;
  logic          is_nl, text_full, table_full, line_bad;
  logic [LW-1:0] q_idx, idx_p1, mid;
  logic [TW-1:0] end_m1, text_len_p1;

  tli_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_waddr),
    .wdata (txt_wdata),
    .re    (txt_re),
    .raddr (txt_raddr),
    .rdata (txt_q)
  );

  tli_ram #(.WIDTH(TW), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_q)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign is_nl       = (in_text_byte == CH_LF);
  assign text_full   = (text_len_r == TW'(TEXT_DEPTH));
  assign table_full  = (line_cnt_r == LW'(LINE_DEPTH));
  assign line_bad    = (in_line_query == '0) || (QW'(in_line_query) > QW'(line_cnt_r));
  assign q_idx       = LW'(in_line_query - LINENO_W'(1));
  assign idx_p1      = idx_r + LW'(1);
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);
  assign end_m1      = end_r - TW'(1);
  assign text_len_p1 = text_len_r + TW'(1);

  always_comb begin
    state_nxt      = state_r;
    text_len_nxt   = text_len_r;
    line_cnt_nxt   = line_cnt_r;
    out_valid_nxt  = out_valid_r;
    off_nxt        = off_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    lo_val_nxt     = lo_val_r;
    idx_nxt        = idx_r;
    zero_nxt       = zero_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_line_nxt   = res_line_r;
    res_col_nxt    = res_col_r;
    res_begin_nxt  = res_begin_r;
    res_len_nxt    = res_len_r;
    out_status_nxt = out_status_r;
    out_line_nxt   = out_line_r;
    out_col_nxt    = out_col_r;
    out_begin_nxt  = out_begin_r;
    out_len_nxt    = out_len_r;
    txt_we         = 1'b0;
    txt_waddr      = text_len_r[TAW-1:0];
    txt_wdata      = in_text_byte;
    txt_re         = 1'b0;
    txt_raddr      = end_m1[TAW-1:0];
    tab_we         = 1'b0;
    tab_waddr      = line_cnt_r[LAW-1:0];
    tab_wdata      = text_len_p1;
    tab_re         = 1'b0;
    tab_raddr      = mid[LAW-1:0];

    // Drop the output transaction once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ST_OK;
          res_line_nxt   = '0;
          res_col_nxt    = '0;
          res_begin_nxt  = '0;
          res_len_nxt    = '0;
          state_nxt      = S_FIN;
          case (in_cmd)
            CMD_APPEND: begin
              if (text_full || (is_nl && table_full)) begin
                res_status_nxt = ST_FULL;
              end else begin
                txt_we       = 1'b1;
                text_len_nxt = text_len_p1;
                // Record the offset after the newline as the next line start
                if (is_nl) begin
                  tab_we       = 1'b1;
                  line_cnt_nxt = line_cnt_r + LW'(1);
                end
              end
            end
            CMD_POS: begin
              // Clamp the offset to the text length
              if (OW'(in_query_offset) > OW'(text_len_r)) begin
                off_nxt = text_len_r;
              end else begin
                off_nxt = TW'(in_query_offset);
              end
              lo_nxt     = '0;
              hi_nxt     = line_cnt_r;
              lo_val_nxt = '0;
              state_nxt  = S_PSRCH;
            end
            CMD_LINE: begin
              if (line_bad) begin
                res_status_nxt = ST_NOLINE;
              end else begin
                tab_re    = 1'b1;
                tab_raddr = q_idx[LAW-1:0];
                idx_nxt   = q_idx;
                zero_nxt  = (q_idx == '0);
                state_nxt = S_LRD0;
              end
            end
            default: begin
              text_len_nxt = '0;
              line_cnt_nxt = LW'(1);
            end
          endcase
        end
      end
      S_PSRCH: begin
        if ((hi_r - lo_r) > LW'(1)) begin
          tab_re    = 1'b1;
          mid_nxt   = mid;
          state_nxt = S_PCMP;
        end else begin
          res_line_nxt = LINE_W'((LW + 1)'(lo_r) + (LW + 1)'(1));
          res_col_nxt  = POS_W'((TW + 1)'(off_r) - (TW + 1)'(lo_val_r) + (TW + 1)'(1));
          state_nxt    = S_FIN;
        end
      end
      S_PCMP: begin
        if (tab_q <= off_r) begin
          lo_nxt     = mid_r;
          lo_val_nxt = tab_q;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_PSRCH;
      end
      S_LRD0: begin
        // Entry zero is never stored; it always reads as 0
        start_nxt = zero_r ? '0 : tab_q;
        if (idx_p1 < line_cnt_r) begin
          tab_re    = 1'b1;
          tab_raddr = idx_p1[LAW-1:0];
          state_nxt = S_LRD1;
        end else begin
          end_nxt   = text_len_r;
          state_nxt = S_TRD;
        end
      end
      S_LRD1: begin
        end_nxt   = tab_q;
        state_nxt = S_TRD;
      end
      S_TRD: begin
        if (end_r > start_r) begin
          txt_re    = 1'b1;
          state_nxt = S_TCMP;
        end else begin
          res_begin_nxt = POS_W'(start_r);
          res_len_nxt   = POS_W'(end_r - start_r);
          state_nxt     = S_FIN;
        end
      end
      S_TCMP: begin
        // Trim one trailing CR or LF, or finish on any other byte
        if (txt_q == CH_LF || txt_q == CH_CR) begin
          end_nxt   = end_m1;
          state_nxt = S_TRD;
        end else begin
          res_begin_nxt = POS_W'(start_r);
          res_len_nxt   = POS_W'(end_r - start_r);
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_line_nxt   = res_line_r;
          out_col_nxt    = res_col_r;
          out_begin_nxt  = res_begin_r;
          out_len_nxt    = res_len_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      text_len_r  <= '0;
      line_cnt_r  <= LW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      text_len_r  <= text_len_nxt;
      line_cnt_r  <= line_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r        <= off_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    lo_val_r     <= lo_val_nxt;
    idx_r        <= idx_nxt;
    zero_r       <= zero_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_line_r   <= res_line_nxt;
    res_col_r    <= res_col_nxt;
    res_begin_r  <= res_begin_nxt;
    res_len_r    <= res_len_nxt;
    out_status_r <= out_status_nxt;
    out_line_r   <= out_line_nxt;
    out_col_r    <= out_col_nxt;
    out_begin_r  <= out_begin_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_line_found   = out_line_r;
  assign out_column_found = out_col_r;
  assign out_line_begin   = out_begin_r;
  assign out_line_length  = out_len_r;

endmodule

// ----- tb/text_line_index_lookup_tb.sv -----
// Self-checking testbench for text_line_index_lookup: random and directed commands
// checked against an in-bench line-index predictor. Depends on tli_pkg and the RTL.
`timescale 1ns / 1ps

module text_line_index_lookup_tb;
  import tli_pkg::*;

  localparam int TEXT_DEPTH  = 4096;
  localparam int LINE_DEPTH  = 1024;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, enough to back up the input
  localparam int TAIL_CYCLES = 100;   // covers the slowest search plus output handshake
  localparam int PHASE_ITEMS = 90;

  // One result transaction, field for field as the block presents it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LINE_W-1:0]   line_no;
    logic [POS_W-1:0]    column_no;
    logic [POS_W-1:0]    start_off;
    logic [POS_W-1:0]    length;
  } lookup_answer_t;

  // Keeps its own copy of the text and line-start table, computes the answer
  // for every accepted command and compares the block's answers in order.
  class line_index_scoreboard;
    logic [BYTE_W-1:0] text_mem[TEXT_DEPTH];
    logic [POS_W-1:0]  start_tab[LINE_DEPTH];
    int unsigned       line_cnt;
    int unsigned       text_len;
    lookup_answer_t    due_answers[$];
    int unsigned       errors;
    int unsigned       n_checked;
    int unsigned       n_cmd[4];
    int unsigned       n_full;
    int unsigned       n_noline;

    function new();
      start_tab[0] = '0;
      line_cnt  = 1;
      text_len  = 0;
      errors    = 0;
      n_checked = 0;
      n_full    = 0;
      n_noline  = 0;
      foreach (n_cmd[i]) n_cmd[i] = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function void accept_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] ch,
                                 logic [OFFSET_W-1:0] q_off, logic [LINENO_W-1:0] q_line);
      lookup_answer_t ans;
      int unsigned    lo, hi, mid, off, idx, first, stop;
      ans = '0;
      n_cmd[cmd]++;
      case (cmd)
        CMD_APPEND: begin
          if (text_len >= TEXT_DEPTH || (ch == CH_LF && line_cnt >= LINE_DEPTH)) begin
            ans.status = ST_FULL;
            n_full++;
          end else begin
            text_mem[text_len] = ch;
            text_len++;
            if (ch == CH_LF) begin
              start_tab[line_cnt] = POS_W'(text_len);
              line_cnt++;
            end
            ans.status = ST_OK;
          end
        end
        CMD_POS: begin
          off = (q_off > text_len) ? text_len : q_off;
          lo  = 0;
          hi  = line_cnt;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (start_tab[mid] <= off) lo = mid;
            else hi = mid;
          end
          ans.status    = ST_OK;
          ans.line_no   = LINE_W'(lo + 1);
          ans.column_no = POS_W'(off - start_tab[lo] + 1);
        end
        CMD_LINE: begin
          if (q_line == 0 || q_line > line_cnt) begin
            ans.status = ST_NOLINE;
            n_noline++;
          end else begin
            idx   = q_line - 1;
            first = start_tab[idx];
            stop  = (idx + 1 < line_cnt) ? start_tab[idx + 1] : text_len;
            while (stop > first && (text_mem[stop-1] == CH_LF || text_mem[stop-1] == CH_CR))
              stop--;
            ans.status    = ST_OK;
            ans.start_off = POS_W'(first);
            ans.length    = POS_W'(stop - first);
          end
        end
        default: begin
          start_tab[0] = '0;
          line_cnt = 1;
          text_len = 0;
          ans.status = ST_OK;
        end
      endcase
      due_answers.push_back(ans);
    endfunction

    task check_answer(lookup_answer_t got);
      lookup_answer_t want;
      if (due_answers.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d", got.status));
      end else begin
        want = due_answers.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.line_no !== want.line_no)
          report($sformatf("line_found got %0d want %0d", got.line_no, want.line_no));
        if (got.column_no !== want.column_no)
          report($sformatf("column_found got %0d want %0d", got.column_no, want.column_no));
        if (got.start_off !== want.start_off)
          report($sformatf("line_begin got %0d want %0d", got.start_off, want.start_off));
        if (got.length !== want.length)
          report($sformatf("line_length got %0d want %0d", got.length, want.length));
      end
    endtask

    task close_out();
      if (due_answers.size() != 0)
        report($sformatf("%0d results never arrived", due_answers.size()));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd;
  logic [BYTE_W-1:0]   in_text_byte;
  logic [OFFSET_W-1:0] in_query_offset;
  logic [LINENO_W-1:0] in_line_query;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [LINE_W-1:0]   out_line_found;
  logic [POS_W-1:0]    out_column_found;
  logic [POS_W-1:0]    out_line_begin;
  logic [POS_W-1:0]    out_line_length;

  line_index_scoreboard sb;

  int unsigned send_idle_pct = 0;  // chance per cycle that the sender holds back
  int unsigned stall_pct     = 0;  // chance per cycle that the receiver drops ready
  int unsigned hold_reqs     = 0;  // bumped by the stimulus to request a long hold-off
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  text_line_index_lookup #(
    .TEXT_DEPTH(TEXT_DEPTH),
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_text_byte     (in_text_byte),
    .in_query_offset  (in_query_offset),
    .in_line_query    (in_line_query),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_line_found   (out_line_found),
    .out_column_found (out_column_found),
    .out_line_begin   (out_line_begin),
    .out_line_length  (out_line_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: drive ready at the falling edge. A requested hold-off is counted
  // down here, cycle by cycle, while the sender keeps offering transactions.
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: sample the result channel at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_answer('{out_status, out_line_found, out_column_found,
                        out_line_begin, out_line_length});
  end

  // Offer one command transaction. Called at a falling edge; returns at the
  // falling edge after acceptance with valid still high, so back-to-back
  // transactions never lower and raise valid in the same step.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] ch,
                          input logic [OFFSET_W-1:0] q_off,
                          input logic [LINENO_W-1:0] q_line);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_text_byte    <= ch;
    in_query_offset <= q_off;
    in_line_query   <= q_line;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_command(cmd, ch, q_off, q_line);
    @(negedge clk);
  endtask

  // Drop valid and hold the sender until every outstanding answer has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.due_answers.size() != 0);
  endtask

  // Mostly well-formed editing traffic: appends biased toward line breaks,
  // queries aimed at the current text and line range, rare clears. Unused
  // fields and a share of the query arguments carry full-range noise.
  task automatic send_random_item();
    int unsigned         pick;
    logic [BYTE_W-1:0]   ch;
    logic [OFFSET_W-1:0] q_off;
    logic [LINENO_W-1:0] q_line;
    pick   = $urandom_range(999);
    ch     = BYTE_W'($urandom);
    q_off  = OFFSET_W'($urandom);
    q_line = LINENO_W'($urandom);
    if (pick < 8) begin
      send_cmd(CMD_CLEAR, ch, q_off, q_line);
    end else if (pick < 560) begin
      case ($urandom_range(9))
        0, 1:    ch = CH_LF;
        2:       ch = CH_CR;
        default: ;
      endcase
      send_cmd(CMD_APPEND, ch, q_off, q_line);
    end else if (pick < 780) begin
      if ($urandom_range(9) != 0) q_off = OFFSET_W'($urandom_range(sb.text_len + 2));
      send_cmd(CMD_POS, ch, q_off, q_line);
    end else begin
      if ($urandom_range(9) != 0) q_line = LINENO_W'($urandom_range(sb.line_cnt + 1));
      send_cmd(CMD_LINE, ch, q_off, q_line);
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) send_random_item();
  endtask

  // Fill the line-start table with mostly empty lines and a few short ones.
  // Interleave queries on the way and request one long receiver hold-off.
  task automatic fill_line_table();
    int unsigned       n;
    logic [BYTE_W-1:0] ch;
    n = 0;
    send_cmd(CMD_CLEAR, '0, '0, '0);
    while (sb.line_cnt < LINE_DEPTH) begin
      case ($urandom_range(15))
        0:       ch = CH_CR;
        1:       ch = BYTE_W'($urandom);
        default: ch = CH_LF;
      endcase
      send_cmd(CMD_APPEND, ch, OFFSET_W'($urandom), LINENO_W'($urandom));
      n++;
      if (n == 300) hold_reqs++;
      if (n % 97 == 0) begin
        send_cmd(CMD_POS, '0, OFFSET_W'($urandom_range(sb.text_len)), '0);
        send_cmd(CMD_LINE, '0, '0, LINENO_W'($urandom_range(sb.line_cnt, 1)));
      end
    end
    // The table is full now: newlines are refused, other bytes still land.
    send_cmd(CMD_APPEND, CH_LF, '0, '0);
    send_cmd(CMD_APPEND, 8'h41, '0, '0);
    send_cmd(CMD_APPEND, CH_CR, '0, '0);
    send_cmd(CMD_APPEND, CH_LF, '0, '0);
    send_cmd(CMD_POS, '0, 16'd0, '0);
    send_cmd(CMD_POS, '0, 16'd4096, '0);
    send_cmd(CMD_POS, '0, 16'h8000, '0);
    send_cmd(CMD_POS, '0, 16'hFFFF, '0);
    send_cmd(CMD_LINE, '0, '0, 16'd1);
    send_cmd(CMD_LINE, '0, '0, 16'd1023);
    send_cmd(CMD_LINE, '0, '0, 16'd1024);
    send_cmd(CMD_LINE, '0, '0, 16'd1025);
    repeat (10) begin
      send_cmd(CMD_POS, '0, OFFSET_W'($urandom_range(sb.text_len + 1)), '0);
      send_cmd(CMD_LINE, '0, '0, LINENO_W'($urandom_range(LINE_DEPTH + 1)));
    end
    send_cmd(CMD_CLEAR, '0, '0, '0);
  endtask

  initial begin
    sb              = new();
    in_valid        = 1'b0;
    in_cmd          = CMD_APPEND;
    in_text_byte    = '0;
    in_query_offset = '0;
    in_line_query   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty text, range edges, CR/LF trimming, empty lines, clear.
    send_cmd(CMD_LINE, '0, '0, 16'd1);          // the single empty line
    send_cmd(CMD_LINE, '0, '0, 16'd0);          // line zero does not exist
    send_cmd(CMD_LINE, '0, '0, 16'd2);
    send_cmd(CMD_LINE, '0, '0, 16'hFFFF);
    send_cmd(CMD_POS, '0, 16'd0, '0);
    send_cmd(CMD_POS, '0, 16'hFFFF, '0);        // clamps to length zero
    send_cmd(CMD_APPEND, 8'h61, '0, '0);
    send_cmd(CMD_APPEND, 8'hFF, '0, '0);
    send_cmd(CMD_APPEND, CH_CR, '0, '0);
    send_cmd(CMD_APPEND, CH_LF, '0, '0);        // line 1 ends in CR LF
    send_cmd(CMD_APPEND, 8'h00, '0, '0);
    send_cmd(CMD_APPEND, CH_LF, '0, '0);
    send_cmd(CMD_APPEND, CH_LF, '0, '0);        // line 3 holds only a newline
    send_cmd(CMD_APPEND, CH_CR, '0, '0);        // last line is a bare CR
    send_cmd(CMD_POS, '0, 16'd2, '0);
    send_cmd(CMD_POS, '0, 16'd4, '0);
    send_cmd(CMD_POS, '0, 16'hFFFF, '0);
    send_cmd(CMD_LINE, '0, '0, 16'd1);
    send_cmd(CMD_LINE, '0, '0, 16'd2);
    send_cmd(CMD_LINE, '0, '0, 16'd3);
    send_cmd(CMD_LINE, '0, '0, 16'd4);
    send_cmd(CMD_LINE, '0, '0, 16'd5);
    send_cmd(CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_POS, '0, 16'd5, '0);
    send_cmd(CMD_LINE, '0, '0, 16'd1);

    fill_line_table();

    // Random traffic across the idling mixes.
    run_phase(0, 0, PHASE_ITEMS);
    hold_reqs++;
    run_phase(79, 0, PHASE_ITEMS);
    wait_drained();
    run_phase(0, 79, PHASE_ITEMS);
    run_phase(19, 19, PHASE_ITEMS);

    stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.close_out();

    $display("Checked %0d answers: %0d appends (%0d refused as full), %0d position queries,",
             sb.n_checked, sb.n_cmd[CMD_APPEND], sb.n_full, sb.n_cmd[CMD_POS]);
    $display("  %0d line queries (%0d past the table), %0d clears; %0d mismatches.",
             sb.n_cmd[CMD_LINE], sb.n_noline, sb.n_cmd[CMD_CLEAR], sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timed out with %0d answers outstanding", sb.due_answers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
